>>> sv/hsvc_pkg.sv
// Shared types, constants and helper functions for the HSV to RGB color path.
// No dependencies; every other file in this folder imports it.
package hsvc_pkg;

    localparam int HUE_W   = 16;
    localparam int CH_W    = 8;
    localparam int CFG_AW  = 4;
    localparam int CFG_DW  = 32;

    localparam logic [5:0]  DEG_SECT    = 6'd60;
    localparam logic [14:0] RECIP60_LO  = 15'd17476;
    localparam logic [14:0] RECIP60_HI  = 15'd17477;
    localparam int          RECIP60_SH  = 20;
    localparam logic [15:0] RECIP6      = 16'd43691;
    localparam int          RECIP6_SH   = 18;
    localparam logic [7:0]  FULL_SCALE  = 8'd255;
    localparam logic [7:0]  ROUND_BIAS  = 8'd127;

    typedef enum logic [1:0] {
        REG_BAL_RED   = 2'd0,
        REG_BAL_GREEN = 2'd1,
        REG_BAL_BLUE  = 2'd2,
        REG_BRIGHT    = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    typedef logic [CH_W-1:0] chan_t;
    typedef chan_t [2:0]     rgb_t;
    typedef logic [13:0]     sprod_t;

    typedef struct packed {
        sector_t sector;
        sprod_t  sfq;
        sprod_t  sft;
        chan_t   sat;
        chan_t   val;
        chan_t   gain;
    } sect_t;

    typedef struct packed {
        rgb_t  rgb;
        chan_t gain;
    } conv_t;

    typedef struct packed {
        chan_t bal_red;
        chan_t bal_green;
        chan_t bal_blue;
        chan_t bright;
    } cfg_t;

    // floor(n / 255), exact for n up to 65152
    function automatic chan_t div255(input logic [15:0] n);
        logic [16:0] sum;
        sum = {1'b0, n} + 17'd1 + {9'd0, n[15:8]};
        return sum[15:8];
    endfunction

endpackage

>>> sv/hsvc_if.sv
// Item channels of the HSV to RGB color path: pixel in, corrected RGB out.
// Depends on hsvc_pkg.
interface hsvc_in_if;
    import hsvc_pkg::*;

    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue_deg;
    chan_t            sat;
    chan_t            val;
    chan_t            gain;

    modport source (output valid, hue_deg, sat, val, gain, input ready);
    modport sink   (input valid, hue_deg, sat, val, gain, output ready);
endinterface

interface hsvc_out_if;
    import hsvc_pkg::*;

    logic  valid;
    logic  ready;
    chan_t red;
    chan_t green;
    chan_t blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> sv/hsvc_sector.sv
// Hue reduction: splits the hue into a 60-degree sector and its remainder,
// and forms the saturation products. Three pipeline stages. Depends on hsvc_pkg.
module hsvc_sector (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [hsvc_pkg::HUE_W-1:0] hue_deg,
    input  hsvc_pkg::chan_t           sat,
    input  hsvc_pkg::chan_t           val,
    input  hsvc_pkg::chan_t           gain,
    output logic                      out_valid,
    input  logic                      out_ready,
    output hsvc_pkg::sect_t           out_data
);
    import hsvc_pkg::*;

    localparam int NST = 3;
    localparam int PW  = HUE_W + 15;
    localparam int QW  = $clog2((2 ** HUE_W - 1) / 60 + 1);
    localparam int Q6W = QW + 16 - RECIP6_SH;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic [NST:0]   stage_ready;

    logic [PW-1:0]    prod_reg;
    logic [HUE_W-1:0] hue1_reg;
    chan_t            sat1_reg;
    chan_t            val1_reg;
    chan_t            gain1_reg;

    logic [QW-1:0] quo_reg;
    logic [QW-1:0] quo_next;
    logic [5:0]    frac_reg;
    logic [5:0]    frac_next;
    chan_t         sat2_reg;
    chan_t         val2_reg;
    chan_t         gain2_reg;

    sect_t sect_reg;
    sect_t sect_next;

    logic [QW-1:0]    quo_est;
    logic [HUE_W-1:0] rem_full;
    logic [6:0]       rem_lo;
    logic [QW+15:0]   q6_prod;
    logic [Q6W-1:0]   q6;
    logic [QW-1:0]    sec_full;

    always_comb
    begin
        stage_ready[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
        valid_next = {valid_reg[NST-2:0], in_valid};
    end

    always_comb
    begin
        quo_est  = prod_reg[RECIP60_SH +: QW];
        rem_full = hue1_reg - HUE_W'(quo_est) * HUE_W'(DEG_SECT);
        rem_lo   = rem_full[6:0];
        if (rem_lo >= {1'b0, DEG_SECT})
        begin
            quo_next  = quo_est + QW'(1);
            frac_next = 6'(rem_lo - {1'b0, DEG_SECT});
        end
        else
        begin
            quo_next  = quo_est;
            frac_next = rem_lo[5:0];
        end
    end

    always_comb
    begin
        q6_prod          = quo_reg * RECIP6;
        q6               = q6_prod[RECIP6_SH +: Q6W];
        sec_full         = quo_reg - QW'(q6) * QW'(3'd6);
        sect_next.sector = sector_t'(sec_full[2:0]);
        sect_next.sfq    = sprod_t'(sat2_reg) * sprod_t'(frac_reg);
        sect_next.sft    = sprod_t'(sat2_reg) * (sprod_t'(DEG_SECT) - sprod_t'(frac_reg));
        sect_next.sat    = sat2_reg;
        sect_next.val    = val2_reg;
        sect_next.gain   = gain2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (stage_ready[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            prod_reg  <= PW'(hue_deg) * PW'(RECIP60_LO);
            hue1_reg  <= hue_deg;
            sat1_reg  <= sat;
            val1_reg  <= val;
            gain1_reg <= gain;
        end
        if (stage_ready[1])
        begin
            quo_reg   <= quo_next;
            frac_reg  <= frac_next;
            sat2_reg  <= sat1_reg;
            val2_reg  <= val1_reg;
            gain2_reg <= gain1_reg;
        end
        if (stage_ready[2])
        begin
            sect_reg <= sect_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[NST-1];
    assign out_data  = sect_reg;

`ifndef SYNTHESIS
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] |-> frac_reg < DEG_SECT)
        else $error("hue remainder out of sector range");

    a_sat_split: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] |-> (16'(sect_reg.sfq) + 16'(sect_reg.sft)
                          == 16'(sect_reg.sat) * 16'(DEG_SECT)))
        else $error("saturation products do not add up to a full sector");
`endif

endmodule

>>> sv/hsvc_convert.sv
// HSV to RGB conversion: per-sector ramp levels p, q, t and channel select.
// Three pipeline stages. Depends on hsvc_pkg.
module hsvc_convert (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  hsvc_pkg::sect_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output hsvc_pkg::conv_t out_data
);
    import hsvc_pkg::*;

    localparam int NST = 3;
    localparam int RW  = 14 + 15;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic [NST:0]   stage_ready;

    chan_t   ka_reg;
    chan_t   kb_reg;
    chan_t   ks_reg;
    sector_t sec1_reg;
    chan_t   val1_reg;
    chan_t   gain1_reg;
    logic    gray1_reg;

    logic [15:0] pn_reg;
    logic [15:0] qn_reg;
    logic [15:0] tn_reg;
    sector_t     sec2_reg;
    chan_t       val2_reg;
    chan_t       gain2_reg;
    logic        gray2_reg;

    conv_t conv_reg;
    conv_t conv_next;

    logic [RW-1:0] qa_prod;
    logic [RW-1:0] ta_prod;
    chan_t         p_lvl;
    chan_t         q_lvl;
    chan_t         t_lvl;

    always_comb
    begin
        stage_ready[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
        valid_next = {valid_reg[NST-2:0], in_valid};
    end

    always_comb
    begin
        qa_prod = RW'(in_data.sfq) * RW'(RECIP60_HI);
        ta_prod = RW'(in_data.sft) * RW'(RECIP60_HI);
    end

    always_comb
    begin
        p_lvl          = div255(pn_reg);
        q_lvl          = div255(qn_reg);
        t_lvl          = div255(tn_reg);
        conv_next.gain = gain2_reg;
        if (gray2_reg)
        begin
            conv_next.rgb = {val2_reg, val2_reg, val2_reg};
        end
        else
        begin
            case (sec2_reg)
                SEC_RED_YEL: conv_next.rgb = {p_lvl, t_lvl, val2_reg};
                SEC_YEL_GRN: conv_next.rgb = {p_lvl, val2_reg, q_lvl};
                SEC_GRN_CYN: conv_next.rgb = {t_lvl, val2_reg, p_lvl};
                SEC_CYN_BLU: conv_next.rgb = {val2_reg, q_lvl, p_lvl};
                SEC_BLU_MAG: conv_next.rgb = {val2_reg, p_lvl, t_lvl};
                default:     conv_next.rgb = {q_lvl, p_lvl, val2_reg};
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (stage_ready[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            ka_reg    <= FULL_SCALE - qa_prod[RECIP60_SH +: CH_W];
            kb_reg    <= FULL_SCALE - ta_prod[RECIP60_SH +: CH_W];
            ks_reg    <= FULL_SCALE - in_data.sat;
            sec1_reg  <= in_data.sector;
            val1_reg  <= in_data.val;
            gain1_reg <= in_data.gain;
            gray1_reg <= (in_data.sat == '0);
        end
        if (stage_ready[1])
        begin
            pn_reg    <= 16'(val1_reg) * 16'(ks_reg);
            qn_reg    <= 16'(val1_reg) * 16'(ka_reg);
            tn_reg    <= 16'(val1_reg) * 16'(kb_reg);
            sec2_reg  <= sec1_reg;
            val2_reg  <= val1_reg;
            gain2_reg <= gain1_reg;
            gray2_reg <= gray1_reg;
        end
        if (stage_ready[2])
        begin
            conv_reg <= conv_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[NST-1];
    assign out_data  = conv_reg;

endmodule

>>> sv/hsvc_scale.sv
// Channel scaling: gain, white balance and brightness, each (x * k + 127) / 255.
// Four pipeline stages, three channels side by side. Depends on hsvc_pkg.
module hsvc_scale (
    input  logic            clk,
    input  logic            rst_n,
    input  hsvc_pkg::cfg_t  cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  hsvc_pkg::conv_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output hsvc_pkg::rgb_t  out_rgb
);
    import hsvc_pkg::*;

    localparam int NST = 4;

    typedef logic [15:0] acc_t;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic [NST:0]   stage_ready;

    acc_t [2:0] n1_reg;
    acc_t [2:0] n1_next;
    acc_t [2:0] n2_reg;
    acc_t [2:0] n2_next;
    acc_t [2:0] n3_reg;
    acc_t [2:0] n3_next;
    rgb_t       rgb_reg;
    rgb_t       rgb_next;
    rgb_t       wb;

    assign wb = {cfg.bal_blue, cfg.bal_green, cfg.bal_red};

    always_comb
    begin
        stage_ready[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
        valid_next = {valid_reg[NST-2:0], in_valid};
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            n1_next[c]  = acc_t'(in_data.rgb[c]) * acc_t'(in_data.gain) + acc_t'(ROUND_BIAS);
            n2_next[c]  = acc_t'(div255(n1_reg[c])) * acc_t'(wb[c]) + acc_t'(ROUND_BIAS);
            n3_next[c]  = acc_t'(div255(n2_reg[c])) * acc_t'(cfg.bright) + acc_t'(ROUND_BIAS);
            rgb_next[c] = div255(n3_reg[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (stage_ready[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            n1_reg <= n1_next;
        end
        if (stage_ready[1])
        begin
            n2_reg <= n2_next;
        end
        if (stage_ready[2])
        begin
            n3_reg <= n3_next;
        end
        if (stage_ready[3])
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[NST-1];
    assign out_rgb   = rgb_reg;

endmodule

>>> sv/hsv_to_rgb_color_correct.sv
// Top level of the HSV to RGB color path: APB register file and pipeline.
// Depends on hsvc_pkg, hsvc_if, hsvc_sector, hsvc_convert and hsvc_scale.
//
// Channel   Dir  Payload                          Handshake
// pix_in    in   hue_deg[15:0] sat val gain       valid/ready
// pix_out   out  red green blue                   valid/ready
// APB       in   balance_red/green/blue, bright   psel/penable, pready tied high
//
// One item per cycle while pix_out is ready (3 hue, 3 conversion, 4 scaling stages).
// Each stage has its own valid bit and takes a new item when empty or when its
// successor takes its item, so bubbles fill while a result waits at pix_out.
// Reset clears the valid bits and sets all four registers to 255; no clearing pass.
module hsv_to_rgb_color_correct (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hsvc_pkg::CFG_AW-1:0] paddr,
    input  logic [hsvc_pkg::CFG_DW-1:0] pwdata,
    output logic [hsvc_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    hsvc_in_if.sink                     pix_in,
    hsvc_out_if.source                  pix_out
);
    import hsvc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     wr_en;
    reg_idx_t wr_idx;

    logic  sect_valid;
    logic  sect_ready;
    sect_t sect_data;
    logic  conv_valid;
    logic  conv_ready;
    conv_t conv_data;
    rgb_t  out_rgb;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_idx)
                REG_BAL_RED:   cfg_next.bal_red   = pwdata[CH_W-1:0];
                REG_BAL_GREEN: cfg_next.bal_green = pwdata[CH_W-1:0];
                REG_BAL_BLUE:  cfg_next.bal_blue  = pwdata[CH_W-1:0];
                REG_BRIGHT:    cfg_next.bright    = pwdata[CH_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (wr_idx)
            REG_BAL_RED:   prdata = CFG_DW'(cfg_reg.bal_red);
            REG_BAL_GREEN: prdata = CFG_DW'(cfg_reg.bal_green);
            REG_BAL_BLUE:  prdata = CFG_DW'(cfg_reg.bal_blue);
            REG_BRIGHT:    prdata = CFG_DW'(cfg_reg.bright);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{bal_red: FULL_SCALE, bal_green: FULL_SCALE,
                         bal_blue: FULL_SCALE, bright: FULL_SCALE};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hsvc_sector u_sector (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .hue_deg   (pix_in.hue_deg),
        .sat       (pix_in.sat),
        .val       (pix_in.val),
        .gain      (pix_in.gain),
        .out_valid (sect_valid),
        .out_ready (sect_ready),
        .out_data  (sect_data)
    );

    hsvc_convert u_convert (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sect_valid),
        .in_ready  (sect_ready),
        .in_data   (sect_data),
        .out_valid (conv_valid),
        .out_ready (conv_ready),
        .out_data  (conv_data)
    );

    hsvc_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (conv_valid),
        .in_ready  (conv_ready),
        .in_data   (conv_data),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .out_rgb   (out_rgb)
    );

    assign pix_out.red   = out_rgb[0];
    assign pix_out.green = out_rgb[1];
    assign pix_out.blue  = out_rgb[2];

`ifndef SYNTHESIS
    a_bright_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && (wr_idx == REG_BRIGHT) |=> cfg_reg.bright == $past(pwdata[CH_W-1:0]))
        else $error("brightness write not taken");

    a_red_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && (wr_idx == REG_BAL_RED)) |=> $stable(cfg_reg.bal_red))
        else $error("red balance changed without a write");
`endif

endmodule
